>>> rtl/rm2q_pkg.sv
// Package for the rotation matrix to quaternion converter: widths, stage
// payload types and the per-stage step functions. No dependencies.
`default_nettype none

package rm2q_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int OUT_W     = 18;
  localparam int N_W       = IN_W + 1;              // off-diagonal sum or difference
  localparam int R_W       = IN_W + 2;              // radicand before scaling
  localparam int RW        = R_W + 1;               // signed radicand width
  localparam int RAD_W     = R_W + FRAC_BITS;       // scaled radicand
  localparam int SQ_STEPS  = RAD_W / 2;
  localparam int S_W       = SQ_STEPS;              // square root width
  localparam int SREM_W    = S_W + 2;
  localparam int D_W       = S_W + 1;               // divisor 2s
  localparam int DREM_W    = D_W + 1;
  localparam int NUM_W     = N_W + FRAC_BITS + 1;   // (mag << FRAC_BITS) + s
  localparam int Q_BITS    = FRAC_BITS + 1;         // quotient bits kept
  localparam int LANES     = 3;

  localparam logic [Q_BITS-1:0] ONE_Q = Q_BITS'(1) << FRAC_BITS;

  localparam logic [1:0] CASE_TRACE = 2'd0;
  localparam logic [1:0] CASE_M00   = 2'd1;
  localparam logic [1:0] CASE_M11   = 2'd2;
  localparam logic [1:0] CASE_M22   = 2'd3;

  typedef struct packed {
    logic [1:0]                        sel;
    logic signed [LANES-1:0][N_W-1:0]  n;
    logic [RAD_W-1:0]                  rad;
    logic [SREM_W-1:0]                 rem;
    logic [S_W-1:0]                    root;
  } sq_t;

  typedef struct packed {
    logic [1:0]                        sel;
    logic                              zero;
    logic [Q_BITS-1:0]                 half;
    logic [D_W-1:0]                    d;
    logic [LANES-1:0]                  neg;
    logic [LANES-1:0]                  ovf;
    logic [LANES-1:0][DREM_W-1:0]      rem;
    logic [LANES-1:0][Q_BITS-1:0]      num;
    logic [LANES-1:0][Q_BITS-1:0]      q;
  } dv_t;

  // One digit of the square root: two radicand bits in, one root bit out.
  function automatic sq_t sq_step(input sq_t a);
    sq_t              o;
    logic [SREM_W-1:0] r2;
    logic [SREM_W-1:0] test;
    o    = a;
    r2   = {a.rem[SREM_W-3:0], a.rad[RAD_W-1 -: 2]};
    test = {a.root, 2'b01};
    o.rad = {a.rad[RAD_W-3:0], 2'b00};
    if (r2 >= test) begin
      o.rem  = r2 - test;
      o.root = {a.root[S_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {a.root[S_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Sets up the three divisions by 2s and the halved root.
  function automatic dv_t dv_prep(input sq_t a);
    dv_t               o;
    logic [S_W:0]      hs;
    logic [N_W-1:0]    mag;
    logic [NUM_W-1:0]  numer;
    logic [N_W-1:0]    top;
    o      = '0;
    o.sel  = a.sel;
    o.zero = (a.root == '0);
    o.d    = {a.root, 1'b0};
    hs     = ({1'b0, a.root} + (S_W+1)'(1)) >> 1;
    o.half = (hs > (S_W+1)'(ONE_Q)) ? ONE_Q : Q_BITS'(hs);
    for (int i = 0; i < LANES; i++) begin
      o.neg[i] = a.n[i][N_W-1];
      mag      = o.neg[i] ? N_W'(-a.n[i]) : N_W'(a.n[i]);
      numer    = {1'b0, mag, {FRAC_BITS{1'b0}}} + NUM_W'(a.root);
      top      = numer[NUM_W-1:Q_BITS];
      o.ovf[i] = DREM_W'(top) >= DREM_W'(o.d);
      o.rem[i] = DREM_W'(top);
      o.num[i] = numer[Q_BITS-1:0];
    end
    return o;
  endfunction

  // One restoring division step in each lane.
  function automatic dv_t dv_step(input dv_t a);
    dv_t               o;
    logic [DREM_W-1:0] r2;
    o = a;
    for (int i = 0; i < LANES; i++) begin
      r2       = {a.rem[i][DREM_W-2:0], a.num[i][Q_BITS-1]};
      o.num[i] = {a.num[i][Q_BITS-2:0], 1'b0};
      if (r2 >= DREM_W'(a.d)) begin
        o.rem[i] = r2 - DREM_W'(a.d);
        o.q[i]   = {a.q[i][Q_BITS-2:0], 1'b1};
      end else begin
        o.rem[i] = r2;
        o.q[i]   = {a.q[i][Q_BITS-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // Saturates a lane magnitude to one and applies its sign.
  function automatic logic signed [OUT_W-1:0] lane_out(input logic ovf, input logic neg,
                                                       input logic [Q_BITS-1:0] q);
    logic [Q_BITS-1:0] m;
    m = (ovf || q > ONE_Q) ? ONE_Q : q;
    return neg ? -OUT_W'(m) : OUT_W'(m);
  endfunction

endpackage

`default_nettype wire

>>> rtl/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
// Depends on rm2q_pkg for widths, stage types and step functions.
`default_nettype none

// Channel  | Valid      | Stall      | Payload
// input    | in_valid   | in_stall   | in_m00 .. in_m22, signed Q1.16
// result   | out_valid  | out_stall  | out_qw .. out_qz Q1.16, out_case_used
//
// Every item passes the same pipeline: one input stage, one stage per
// square root digit, one setup stage, one stage per quotient bit and the
// output register, and one matrix can enter in every cycle unless a held
// result stalls the pipeline. The depth is set by the digit-by-digit square
// root and the three lane restoring dividers.
// Reset clears only the valid bits. A stalled result freezes every stage.
module rotation_matrix_to_quaternion
  import rm2q_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [IN_W-1:0]  in_m00,
  input  wire logic signed [IN_W-1:0]  in_m01,
  input  wire logic signed [IN_W-1:0]  in_m02,
  input  wire logic signed [IN_W-1:0]  in_m10,
  input  wire logic signed [IN_W-1:0]  in_m11,
  input  wire logic signed [IN_W-1:0]  in_m12,
  input  wire logic signed [IN_W-1:0]  in_m20,
  input  wire logic signed [IN_W-1:0]  in_m21,
  input  wire logic signed [IN_W-1:0]  in_m22,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      out_qw,
  output logic signed [OUT_W-1:0]      out_qx,
  output logic signed [OUT_W-1:0]      out_qy,
  output logic signed [OUT_W-1:0]      out_qz,
  output logic [1:0]                   out_case_used
);

  logic                      adv;
  logic [SQ_STEPS:0]         sq_v_r;
  sq_t                       sq_r   [SQ_STEPS+1];
  sq_t                       sq_nxt [SQ_STEPS+1];
  logic [Q_BITS:0]           dv_v_r;
  dv_t                       dv_r   [Q_BITS+1];
  dv_t                       dv_nxt [Q_BITS+1];
  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   qw_r, qx_r, qy_r, qz_r;
  logic signed [OUT_W-1:0]   qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic [1:0]                case_r;

  logic signed [RW-1:0]      tr, rr;
  logic [1:0]                sel;

  // The whole pipeline moves unless a finished result is held.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Input stage: case selection, radicand and the off-diagonal numerators.
  always_comb begin
    sq_nxt[0] = '0;
    tr = RW'(in_m00) + RW'(in_m11) + RW'(in_m22);
    if (tr > 0) begin
      sel = CASE_TRACE;
    end else if (in_m00 > in_m11 && in_m00 > in_m22) begin
      sel = CASE_M00;
    end else if (in_m11 > in_m22) begin
      sel = CASE_M11;
    end else begin
      sel = CASE_M22;
    end
    unique case (sel)
      CASE_TRACE: begin
        rr = RW'(ONE_Q) + tr;
        sq_nxt[0].n[0] = N_W'(in_m21) - N_W'(in_m12);
        sq_nxt[0].n[1] = N_W'(in_m02) - N_W'(in_m20);
        sq_nxt[0].n[2] = N_W'(in_m10) - N_W'(in_m01);
      end
      CASE_M00: begin
        rr = RW'(ONE_Q) + RW'(in_m00) - RW'(in_m11) - RW'(in_m22);
        sq_nxt[0].n[0] = N_W'(in_m01) + N_W'(in_m10);
        sq_nxt[0].n[1] = N_W'(in_m20) + N_W'(in_m02);
        sq_nxt[0].n[2] = N_W'(in_m21) - N_W'(in_m12);
      end
      CASE_M11: begin
        rr = RW'(ONE_Q) + RW'(in_m11) - RW'(in_m00) - RW'(in_m22);
        sq_nxt[0].n[0] = N_W'(in_m01) + N_W'(in_m10);
        sq_nxt[0].n[1] = N_W'(in_m12) + N_W'(in_m21);
        sq_nxt[0].n[2] = N_W'(in_m02) - N_W'(in_m20);
      end
      default: begin
        rr = RW'(ONE_Q) + RW'(in_m22) - RW'(in_m00) - RW'(in_m11);
        sq_nxt[0].n[0] = N_W'(in_m02) + N_W'(in_m20);
        sq_nxt[0].n[1] = N_W'(in_m12) + N_W'(in_m21);
        sq_nxt[0].n[2] = N_W'(in_m10) - N_W'(in_m01);
      end
    endcase
    sq_nxt[0].sel = sel;
    // A radicand that is not positive gives a zero root and a zero result.
    sq_nxt[0].rad = (rr > 0) ? {rr[R_W-1:0], {FRAC_BITS{1'b0}}} : '0;
    for (int k = 1; k <= SQ_STEPS; k++) begin
      sq_nxt[k] = sq_step(sq_r[k-1]);
    end
  end

  always_comb begin
    dv_nxt[0] = dv_prep(sq_r[SQ_STEPS]);
    for (int k = 1; k <= Q_BITS; k++) begin
      dv_nxt[k] = dv_step(dv_r[k-1]);
    end
  end

  // Output mapping: the halved root goes to the chosen component, three quotients
  // fill the rest in lane order and lane 2 moves to qw outside the trace case.
  always_comb begin
    logic signed [OUT_W-1:0] l0, l1, l2, hv;
    l0 = lane_out(dv_r[Q_BITS].ovf[0], dv_r[Q_BITS].neg[0], dv_r[Q_BITS].q[0]);
    l1 = lane_out(dv_r[Q_BITS].ovf[1], dv_r[Q_BITS].neg[1], dv_r[Q_BITS].q[1]);
    l2 = lane_out(dv_r[Q_BITS].ovf[2], dv_r[Q_BITS].neg[2], dv_r[Q_BITS].q[2]);
    hv = OUT_W'(dv_r[Q_BITS].half);
    unique case (dv_r[Q_BITS].sel)
      CASE_TRACE: begin
        qw_nxt = hv; qx_nxt = l0; qy_nxt = l1; qz_nxt = l2;
      end
      CASE_M00: begin
        qw_nxt = l2; qx_nxt = hv; qy_nxt = l0; qz_nxt = l1;
      end
      CASE_M11: begin
        qw_nxt = l2; qx_nxt = l0; qy_nxt = hv; qz_nxt = l1;
      end
      default: begin
        qw_nxt = l2; qx_nxt = l0; qy_nxt = l1; qz_nxt = hv;
      end
    endcase
    if (dv_r[Q_BITS].zero) begin
      qw_nxt = '0; qx_nxt = '0; qy_nxt = '0; qz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r      <= '0;
      dv_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sq_v_r      <= {sq_v_r[SQ_STEPS-1:0], in_valid};
      dv_v_r      <= {dv_v_r[Q_BITS-1:0], sq_v_r[SQ_STEPS]};
      out_valid_r <= dv_v_r[Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sq_r[k] <= sq_nxt[k];
      end
      for (int k = 0; k <= Q_BITS; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
      qw_r   <= qw_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      qz_r   <= qz_nxt;
      case_r <= dv_r[Q_BITS].sel;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_qw        = qw_r;
  assign out_qx        = qx_r;
  assign out_qy        = qy_r;
  assign out_qz        = qz_r;
  assign out_case_used = case_r;

  // The input is held off exactly when a finished result is waiting.
  a_stall_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output hold");

  // Saturation keeps every component within plus or minus one; qw and qx are checked.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_qw <= $signed(OUT_W'(ONE_Q)) && out_qw >= -$signed(OUT_W'(ONE_Q))
                && out_qx <= $signed(OUT_W'(ONE_Q)) && out_qx >= -$signed(OUT_W'(ONE_Q))))
    else $error("quaternion component out of range");

  // The component formed from the root is never negative.
  a_root_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_case_used == CASE_TRACE && out_qw >= 0)
                || (out_case_used == CASE_M00 && out_qx >= 0)
                || (out_case_used == CASE_M11 && out_qy >= 0)
                || (out_case_used == CASE_M22 && out_qz >= 0)))
    else $error("root component negative");

endmodule

`default_nettype wire

>>> tb/rotation_matrix_to_quaternion_tb.sv
// Testbench for the rotation matrix to quaternion converter: drives matrices,
// predicts each quaternion and case, and checks the results in order.
// Depends on rm2q_pkg and the rotation_matrix_to_quaternion RTL.
`timescale 1ns / 1ps

typedef struct {
  logic signed [17:0] qw, qx, qy, qz;
  logic [1:0]         sel;
} quat_t;

class quat_scoreboard;
  quat_t pending[$];
  int    errors;

  function new();
    errors = 0;
  endfunction

  // Integer square root, floor.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // n * ONE / (2s), rounded to nearest with ties away from zero.
  function automatic longint div_by_2s(longint n, longint unsigned s);
    longint unsigned mag, q;
    mag = (n < 0) ? -n : n;
    q = ((mag << 16) + s) / (s * 2);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [17:0] clamp_one(longint v);
    if (v > 65536) return 18'sd65536;
    if (v < -65536) return -18'sd65536;
    return v[17:0];
  endfunction

  // Notes an accepted matrix and queues its expected quaternion.
  function void note_matrix(input logic signed [17:0] m[9]);
    longint a[9];
    longint tr, r, nw, nx, ny, nz, w, x, y, z, half;
    longint unsigned s;
    logic [1:0] sel;
    quat_t e;
    foreach (m[i]) a[i] = m[i];
    nw = 0; nx = 0; ny = 0; nz = 0; w = 0; x = 0; y = 0; z = 0;
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      sel = rm2q_pkg::CASE_TRACE; r = 65536 + tr;
      nx = a[7] - a[5]; ny = a[2] - a[6]; nz = a[3] - a[1];
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      sel = rm2q_pkg::CASE_M00; r = 65536 + a[0] - a[4] - a[8];
      ny = a[1] + a[3]; nz = a[6] + a[2]; nw = a[7] - a[5];
    end else if (a[4] > a[8]) begin
      sel = rm2q_pkg::CASE_M11; r = 65536 + a[4] - a[0] - a[8];
      nx = a[1] + a[3]; nz = a[5] + a[7]; nw = a[2] - a[6];
    end else begin
      sel = rm2q_pkg::CASE_M22; r = 65536 + a[8] - a[0] - a[4];
      nx = a[2] + a[6]; ny = a[5] + a[7]; nw = a[3] - a[1];
    end
    s = (r > 0) ? root_floor(longint'(r) << 16) : 0;
    if (s != 0) begin
      half = (s + 1) >> 1;
      w = (sel == rm2q_pkg::CASE_TRACE) ? half : div_by_2s(nw, s);
      x = (sel == rm2q_pkg::CASE_M00) ? half : div_by_2s(nx, s);
      y = (sel == rm2q_pkg::CASE_M11) ? half : div_by_2s(ny, s);
      z = (sel == rm2q_pkg::CASE_M22) ? half : div_by_2s(nz, s);
    end
    e.qw = clamp_one(w); e.qx = clamp_one(x);
    e.qy = clamp_one(y); e.qz = clamp_one(z);
    e.sel = sel;
    pending.push_back(e);
  endfunction

  function void check_quat(input quat_t got);
    quat_t e;
    if (pending.size() == 0) begin
      $error("result with no matrix pending");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.qw !== e.qw) begin $error("qw exp %0d got %0d", e.qw, got.qw); errors++; end
    if (got.qx !== e.qx) begin $error("qx exp %0d got %0d", e.qx, got.qx); errors++; end
    if (got.qy !== e.qy) begin $error("qy exp %0d got %0d", e.qy, got.qy); errors++; end
    if (got.qz !== e.qz) begin $error("qz exp %0d got %0d", e.qz, got.qz); errors++; end
    if (got.sel !== e.sel) begin
      $error("case_used exp %0d got %0d", e.sel, got.sel);
      errors++;
    end
  endfunction
endclass

module rotation_matrix_to_quaternion_tb;
  import rm2q_pkg::*;

  // The pipeline is 38 stages deep; the drain wait covers that with margin.
  localparam int PIPE_DEPTH  = 38;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] in_m[9];
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_qw, out_qx, out_qy, out_qz;
  logic [1:0] out_case_used;

  // Idle percentages for the sender and the receiver, per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_count = 0;
  quat_scoreboard quat_sb;

  initial foreach (in_m[i]) in_m[i] = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rotation_matrix_to_quaternion i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_qw(out_qw), .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz),
    .out_case_used(out_case_used)
  );

  // The receiver checks every result transfer and picks its next stall at
  // the same edge, so the stall value never races the sampled handshake.
  always @(posedge clk) begin
    quat_t got;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      got.qw = out_qw; got.qx = out_qx; got.qy = out_qy; got.qz = out_qz;
      got.sel = out_case_used;
      quat_sb.check_quat(got);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rotation_matrix_to_quaternion");
      $finish;
    end
  end

  // Presents one matrix and holds it until the transfer happens. Random
  // sender gaps are inserted before valid is raised, never while it is high.
  task automatic send_matrix(input logic signed [IN_W-1:0] m[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    foreach (m[i]) in_m[i] <= m[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quat_sb.note_matrix(m);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (quat_sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] rand_elem();
    case ($urandom_range(9))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'(signed'($urandom_range(131071)) - 131072);
      3: return 18'(signed'($urandom_range(131071)));
      default: return 18'(signed'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // Builds a near-orthonormal matrix from a random unit quaternion, so that
  // every case of the largest-diagonal choice is reached with valid data.
  task automatic make_rotation(output logic signed [IN_W-1:0] m[9]);
    real qa, qb, qc, qd, nrm;
    real f[9];
    qa = $urandom_range(2000) - 1000.0; qb = $urandom_range(2000) - 1000.0;
    qc = $urandom_range(2000) - 1000.0; qd = $urandom_range(2000) - 1000.0;
    nrm = $sqrt(qa*qa + qb*qb + qc*qc + qd*qd) + 1e-9;
    qa /= nrm; qb /= nrm; qc /= nrm; qd /= nrm;
    f[0] = 1 - 2*(qc*qc + qd*qd); f[1] = 2*(qb*qc - qa*qd); f[2] = 2*(qb*qd + qa*qc);
    f[3] = 2*(qb*qc + qa*qd); f[4] = 1 - 2*(qb*qb + qd*qd); f[5] = 2*(qc*qd - qa*qb);
    f[6] = 2*(qb*qd - qa*qc); f[7] = 2*(qc*qd + qa*qb); f[8] = 1 - 2*(qb*qb + qc*qc);
    foreach (f[i]) begin
      int v;
      v = $rtoi(f[i] * 65536.0) + int'($urandom_range(4)) - 2;
      if (v > 65536) v = 65536;
      if (v < -65536) v = -65536;
      m[i] = v[17:0];
    end
  endtask

  task automatic send_diag(input int d0, input int d1, input int d2, input int off);
    logic signed [IN_W-1:0] m[9];
    foreach (m[i]) m[i] = off[17:0];
    m[0] = d0[17:0]; m[4] = d1[17:0]; m[8] = d2[17:0];
    send_matrix(m);
  endtask

  initial begin
    logic signed [IN_W-1:0] m[9];
    quat_sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity and each case, ties between diagonal elements,
    // zero trace, full-scale elements and radicands that are not positive.
    send_diag(65536, 65536, 65536, 0);
    send_diag(65536, -65536, -65536, 0);
    send_diag(-65536, 65536, -65536, 0);
    send_diag(-65536, -65536, 65536, 0);
    send_diag(0, 0, 0, 0);
    send_diag(1, 0, -1, 65536);
    send_diag(-65536, -65536, -65536, 0);
    send_diag(-65536, -65536, -65536, 65536);
    send_diag(0, 0, 0, -65536);
    send_diag(-131072, -131072, -131072, -131072);
    send_diag(131071, 131071, 131071, 131071);
    send_diag(-131072, 131071, -131072, 131071);
    send_diag(131071, -131072, -131072, -131072);
    send_diag(-20000, -20000, -30000, 5000);
    send_diag(-30000, -20000, -20000, 5000);
    send_diag(-20000, -30000, -20000, -5000);
    send_diag(1, -1, -1, 3);
    send_diag(-65536, 65536, 65536, 0);
    foreach (m[i]) m[i] = (i % 2) ? 18'sh1FFFF : -18'sh20000;
    send_matrix(m);
    foreach (m[i]) m[i] = (i % 2) ? -18'sh20000 : 18'sh1FFFF;
    send_matrix(m);
    foreach (m[i]) m[i] = 18'sh15555;
    send_matrix(m);
    foreach (m[i]) m[i] = 18'sh0AAAA;
    send_matrix(m);

    // The sender holds off until the pipeline has emptied completely.
    wait_drained();

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 59) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 17 : 59) : 0;
      for (int k = 0; k < 400; k++) begin
        if ($urandom_range(99) < 75) make_rotation(m);
        else foreach (m[i]) m[i] = rand_elem();
        send_matrix(m);
      end
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (quat_sb.errors == 0 && quat_sb.pending.size() == 0) begin
      $display("PASS rotation_matrix_to_quaternion");
    end else begin
      $display("FAIL rotation_matrix_to_quaternion");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/rm2q_pkg.sv
rtl/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_tb.sv
